### hdl/bdq_pkg.sv
package bdq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int TOTAL_W  = 5;

  typedef enum logic [1:0] {
    FN_PUSH_FRONT = 2'd0,
    FN_PUSH_TAIL  = 2'd1,
    FN_POP_FRONT  = 2'd2,
    FN_DELETE     = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic  commit;
    func_t func;
  } cell_ctl_t;

endpackage

### hdl/bounded_deque_delete_by_value.sv
// Bounded deque of up to 16 signed 32-bit entries held in a row of cells, one entry per
// cell. A beat on in_ carries an operation in in_tuser (push front, push tail, pop front,
// delete first match) and a value in in_tdata. Every cell compares and shifts its own
// entry, so the whole operation, delete included, is done in the cycle of acceptance; the
// report state then reads head and tail out of the cells into the output register, once
// out_ is empty or its beat is taken. The input takes no new beat until that load, but
// takes one while an earlier result still waits on out_. Each accepted beat yields exactly
// one result beat with status, entry count, front and back values (zero when empty).
module bounded_deque_delete_by_value
  import bdq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] item_value
  input  logic [1:0]  in_tuser,   // [1:0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [4:0] entry_total, [36:5] front_value,
                                  // [68:37] back_value, [71:69] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_REPORT = 2'b10
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  status_t          status_r, status_nxt;
  logic             out_tvalid_r, out_tvalid_nxt;
  logic [71:0]      out_tdata_r;
  logic [1:0]       out_tuser_r;

  logic             accept;
  logic             load;
  logic             is_full;
  logic             is_empty;
  logic             found;
  func_t            func;
  cell_ctl_t        ctl;
  logic [VAL_W-1:0] front_val;
  logic [VAL_W-1:0] back_val;

  assign func      = func_t'(in_tuser);
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid & in_tready;
  assign load      = (state_r == S_REPORT) & (~out_tvalid_r | out_tready);
  assign is_full   = (count_r == CNT_W'(CAPACITY));
  assign is_empty  = (count_r == '0);

  bdq_chain u_chain (
    .clk        (clk),
    .ctl        (ctl),
    .item_value (in_tdata),
    .count      (count_r),
    .found      (found),
    .front_val  (front_val),
    .back_val   (back_val)
  );

  always_comb begin
    ctl.func   = func;
    ctl.commit = 1'b0;
    count_nxt  = count_r;
    status_nxt = status_r;
    if (accept) begin
      status_nxt = ST_DONE;
      case (func)
        FN_PUSH_FRONT, FN_PUSH_TAIL: begin
          if (is_full) begin
            status_nxt = ST_FULL;
          end else begin
            ctl.commit = 1'b1;
            count_nxt  = count_r + 1'b1;
          end
        end
        FN_POP_FRONT: begin
          if (is_empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            ctl.commit = 1'b1;
            count_nxt  = count_r - 1'b1;
          end
        end
        FN_DELETE: begin
          if (is_empty) begin
            status_nxt = ST_EMPTY;
          end else if (!found) begin
            status_nxt = ST_NOT_FOUND;
          end else begin
            ctl.commit = 1'b1;
            count_nxt  = count_r - 1'b1;
          end
        end
        default: status_nxt = ST_DONE;
      endcase
    end
  end

  always_comb begin
    state_nxt      = state_r;
    out_tvalid_nxt = out_tvalid_r;
    if (out_tready) out_tvalid_nxt = 1'b0;
    case (state_r)
      S_IDLE:   if (accept) state_nxt = S_REPORT;
      S_REPORT: begin
        if (load) begin
          state_nxt      = S_IDLE;
          out_tvalid_nxt = 1'b1;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    if (load) begin
      out_tdata_r <= {3'b000, back_val, front_val, TOTAL_W'(count_r)};
      out_tuser_r <= status_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> count_r == $past(count_r))
    else $error("entry count changed without an accepted beat");

  a_report_load: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_tvalid && state_r == S_IDLE)
    else $error("result not presented after report");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("input taken while a result is still being formed");

endmodule

### hdl/bdq_cell.sv
module bdq_cell
  import bdq_pkg::*;
(
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [VAL_W-1:0] item_value,
  input  logic [VAL_W-1:0] lower_val,
  input  logic [VAL_W-1:0] upper_val,
  input  logic             occ,
  input  logic             tail_here,
  input  logic             seen_in,
  output logic             seen_out,
  output logic [VAL_W-1:0] val
);

  logic [VAL_W-1:0] val_r;
  logic [VAL_W-1:0] val_nxt;

  assign seen_out = seen_in | (occ && (val_r == item_value));
  assign val      = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctl.commit) begin
      case (ctl.func)
        FN_PUSH_FRONT: val_nxt = lower_val;
        FN_PUSH_TAIL:  if (tail_here) val_nxt = item_value;
        FN_POP_FRONT:  val_nxt = upper_val;
        FN_DELETE:     if (seen_out) val_nxt = upper_val;
        default:       val_nxt = val_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

### hdl/bdq_chain.sv
module bdq_chain
  import bdq_pkg::*;
(
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [VAL_W-1:0] item_value,
  input  logic [CNT_W-1:0] count,
  output logic             found,
  output logic [VAL_W-1:0] front_val,
  output logic [VAL_W-1:0] back_val
);

  logic [VAL_W-1:0] vals [CAPACITY];
  logic [VAL_W-1:0] masked [CAPACITY];
  logic             occ [CAPACITY];
  logic             seen [CAPACITY+1];

  assign seen[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VAL_W-1:0] lower;
    logic [VAL_W-1:0] upper;
    logic             last;

    assign occ[i] = (CNT_W'(i) < count);

    if (i == 0) begin : g_first
      assign lower = item_value;
    end else begin : g_mid
      assign lower = vals[i-1];
    end

    if (i == CAPACITY - 1) begin : g_end
      assign upper = vals[i];
      assign last  = occ[i];
    end else begin : g_inner
      assign upper = vals[i+1];
      assign last  = occ[i] & ~occ[i+1];
    end

    assign masked[i] = vals[i] & {VAL_W{last}};

    bdq_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .item_value (item_value),
      .lower_val  (lower),
      .upper_val  (upper),
      .occ        (occ[i]),
      .tail_here  (CNT_W'(i) == count),
      .seen_in    (seen[i]),
      .seen_out   (seen[i+1]),
      .val        (vals[i])
    );
  end

  assign found     = seen[CAPACITY];
  assign front_val = vals[0] & {VAL_W{occ[0]}};

  always_comb begin
    logic [VAL_W-1:0] acc;
    acc = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      acc = acc | masked[i];
    end
    back_val = acc;
  end

endmodule

### sim/bounded_deque_delete_by_value_tb.sv
`timescale 1ns / 100ps

module bounded_deque_delete_by_value_tb;
  import bdq_pkg::*;

  typedef struct {
    func_t            op;
    logic [VAL_W-1:0] value;
  } deque_req_t;

  typedef struct {
    status_t            status;
    logic [TOTAL_W-1:0] total;
    logic [VAL_W-1:0]   front;
    logic [VAL_W-1:0]   back;
  } deque_view_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;    // [31:0] item_value
  logic [1:0]  in_tuser = '0;    // [1:0] func
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;        // [4:0] entry_total, [36:5] front_value, [68:37] back_value
  logic [1:0]  out_tuser;        // [1:0] status

  deque_req_t       pending_q[$];
  deque_view_t      view_q[$];
  logic [VAL_W-1:0] deque_image[$];
  logic [VAL_W-1:0] pushed_hist[$];

  int   total_items = 0;
  int   sent_cnt = 0;
  int   seen_cnt = 0;
  int   mismatch_cnt = 0;
  int   hold_cnt = 0;
  bit   hold_done = 1'b0;
  logic [1:0] idle_phase = 2'd0;

  bounded_deque_delete_by_value u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic deque_view_t apply_request(deque_req_t req);
    deque_view_t r;
    int          hit;
    r.status = ST_DONE;
    hit = -1;
    case (req.op)
      FN_PUSH_FRONT: begin
        if (deque_image.size() >= CAPACITY) r.status = ST_FULL;
        else deque_image.push_front(req.value);
      end
      FN_PUSH_TAIL: begin
        if (deque_image.size() >= CAPACITY) r.status = ST_FULL;
        else deque_image.push_back(req.value);
      end
      FN_POP_FRONT: begin
        if (deque_image.size() == 0) r.status = ST_EMPTY;
        else void'(deque_image.pop_front());
      end
      default: begin
        if (deque_image.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          for (int k = 0; k < deque_image.size(); k++)
            if (hit < 0 && deque_image[k] == req.value) hit = k;
          if (hit < 0) r.status = ST_NOT_FOUND;
          else deque_image.delete(hit);
        end
      end
    endcase
    r.total = TOTAL_W'(deque_image.size());
    r.front = (deque_image.size() == 0) ? '0 : deque_image[0];
    r.back  = (deque_image.size() == 0) ? '0 : deque_image[deque_image.size() - 1];
    return r;
  endfunction

  task automatic queue_item(func_t op, logic [VAL_W-1:0] value);
    deque_req_t req;
    req.op = op;
    req.value = value;
    pending_q.push_back(req);
    if (op == FN_PUSH_FRONT || op == FN_PUSH_TAIL) begin
      pushed_hist.push_back(value);
      if (pushed_hist.size() > 16) void'(pushed_hist.pop_front());
    end
  endtask

  function automatic logic [VAL_W-1:0] pick_value(bit want_dup);
    logic [VAL_W-1:0] pool [4];
    pool = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000};
    if (want_dup && pushed_hist.size() > 0 && $urandom_range(0, 99) < 75)
      return pushed_hist[$urandom_range(0, pushed_hist.size() - 1)];
    if ($urandom_range(0, 99) < 20) return pool[$urandom_range(0, 3)];
    return $urandom;
  endfunction

  // sender: hold a beat until taken, then offer the next one or idle
  always @(posedge clk) begin
    deque_req_t nxt;
    int         pct;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        nxt.op = func_t'(in_tuser);
        nxt.value = in_tdata;
        view_q.push_back(apply_request(nxt));
        sent_cnt++;
        idle_phase <= (sent_cnt < total_items / 3) ? 2'd0 :
                      (sent_cnt < 2 * total_items / 3) ? 2'd1 : 2'd2;
      end
      if (!in_tvalid || in_tready) begin
        pct = (idle_phase == 2'd0) ? 17 : (idle_phase == 2'd1) ? 87 : 0;
        if (pending_q.size() > 0 && $urandom_range(0, 99) >= pct) begin
          nxt = pending_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= nxt.value;
          in_tuser  <= nxt.op;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: compare each result beat with the oldest prediction
  always @(posedge clk) begin
    deque_view_t exp_v;
    int          pct;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        seen_cnt++;
        if (view_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("beat %0d: unexpected result tuser=%0d tdata=%h",
                     seen_cnt, out_tuser, out_tdata);
        end else begin
          exp_v = view_q.pop_front();
          if (out_tuser !== exp_v.status || out_tdata[4:0] !== exp_v.total ||
              out_tdata[36:5] !== exp_v.front || out_tdata[68:37] !== exp_v.back) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("beat %0d: exp st=%0d n=%0d f=%h b=%h got st=%0d n=%0d f=%h b=%h",
                       seen_cnt, exp_v.status, exp_v.total, exp_v.front, exp_v.back,
                       out_tuser, out_tdata[4:0], out_tdata[36:5], out_tdata[68:37]);
          end
        end
        if (!hold_done && seen_cnt == 330) begin
          hold_done = 1'b1;
          hold_cnt = 120;
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_tready <= 1'b0;
      end else begin
        pct = (idle_phase == 2'd0) ? 87 : (idle_phase == 2'd1) ? 17 : 0;
        out_tready <= ($urandom_range(0, 99) >= pct);
      end
    end
  end

  initial begin
    logic [VAL_W-1:0] seed_vals [16];
    int               r;
    bit               grow;
    seed_vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'h0000_0005, 32'h0000_0006, 32'h0000_0007,
                  32'h0000_0008, 32'h0000_0009, 32'h0000_000A, 32'h0000_000B,
                  32'h0000_000C, 32'h0000_000D, 32'hA5A5_A5A5, 32'h5A5A_5A5A};

    queue_item(FN_POP_FRONT, 32'h0000_0000);
    queue_item(FN_DELETE, 32'h1234_5678);
    queue_item(FN_PUSH_TAIL, 32'h7FFF_FFFF);
    queue_item(FN_DELETE, 32'h7FFF_FFFF);
    for (int i = 0; i < 16; i++)
      queue_item(i[0] ? FN_PUSH_TAIL : FN_PUSH_FRONT, seed_vals[i]);
    queue_item(FN_PUSH_FRONT, 32'h0000_0001);
    queue_item(FN_PUSH_TAIL, 32'h0000_0002);
    queue_item(FN_DELETE, 32'h1234_5678);
    queue_item(FN_DELETE, 32'hA5A5_A5A5);
    queue_item(FN_DELETE, 32'h5A5A_5A5A);
    queue_item(FN_DELETE, 32'hFFFF_FFFF);
    queue_item(FN_POP_FRONT, 32'h0000_0000);

    grow = 1'b1;
    for (int i = 0; i < 400; i++) begin
      if (i % 40 == 0) grow = ~grow;
      r = $urandom_range(0, 99);
      if (grow) begin
        if (r < 35) queue_item(FN_PUSH_FRONT, pick_value(1'b0));
        else if (r < 70) queue_item(FN_PUSH_TAIL, pick_value(1'b0));
        else if (r < 85) queue_item(FN_POP_FRONT, $urandom);
        else queue_item(FN_DELETE, pick_value(1'b1));
      end else begin
        if (r < 15) queue_item(FN_PUSH_FRONT, pick_value(1'b0));
        else if (r < 30) queue_item(FN_PUSH_TAIL, pick_value(1'b0));
        else if (r < 65) queue_item(FN_POP_FRONT, $urandom);
        else queue_item(FN_DELETE, pick_value(1'b1));
      end
    end
    total_items = pending_q.size();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_q.size() != 0 || in_tvalid) @(posedge clk);
    while (view_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0 && view_q.size() == 0)
      $display("PASS bounded_deque_delete_by_value");
    else
      $display("FAIL bounded_deque_delete_by_value");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("FAIL bounded_deque_delete_by_value");
    $finish;
  end

endmodule

### filelist.f
hdl/bdq_pkg.sv
hdl/bdq_cell.sv
hdl/bdq_chain.sv
hdl/bounded_deque_delete_by_value.sv
sim/bounded_deque_delete_by_value_tb.sv
